// ===== sv/cst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants of the cyclic sequence run tokenizer
// widths, token kinds, register indexes and the step interface structs
// ----------------------------------------------------------------------------
package cst_pkg;

    localparam int MAX_KEY_LEN = 8;
    localparam int CHAR_W      = 8;
    localparam int KEY_W       = MAX_KEY_LEN * CHAR_W;
    localparam int KEY_LEN_W   = 4;
    localparam int KEY_POS_W   = $clog2(MAX_KEY_LEN);
    localparam int RUN_W       = 16;
    localparam int CFG_IDX_W   = 1;

    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_CHARS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 1'd1;

    // request types
    localparam logic REQ_CHAR = 1'b0;
    localparam logic REQ_EOI  = 1'b1;

    // dropped characters
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_RUN      = 2'd0,
        KIND_BOX_CHAR = 2'd1,
        KIND_BOX_END  = 2'd2
    } token_kind_t;

    typedef struct packed {
        token_kind_t        token_kind;
        logic [RUN_W-1:0]   run_length;
        logic [CHAR_W-1:0]  box_byte;
        logic               last_of_step;
    } result_t;

    typedef struct packed {
        logic [KEY_POS_W-1:0] key_pos;
        logic [RUN_W-1:0]     run_count;
        logic                 box_open;
    } tok_state_t;

    typedef struct packed {
        logic [KEY_W-1:0]     key_chars;
        logic [KEY_LEN_W-1:0] key_length;
    } tok_cfg_t;

    typedef struct packed {
        tok_state_t  state_next;
        result_t     res0;
        result_t     res1;
        logic [1:0]  res_cnt;
    } step_out_t;

endpackage
`default_nettype wire

// ===== sv/cst_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cst_if: request and token channel interfaces
// valid/ready handshake channels carrying the tokenizer payloads
// ----------------------------------------------------------------------------
interface cst_req_if;
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [cst_pkg::CHAR_W-1:0] in_char;

    modport source (output valid, output req_type, output in_char, input ready);
    modport sink   (input valid, input req_type, input in_char, output ready);
endinterface

interface cst_tok_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 token_kind;
    logic [cst_pkg::RUN_W-1:0]  run_length;
    logic [cst_pkg::CHAR_W-1:0] box_byte;
    logic                       last_of_step;

    modport source (output valid, output token_kind, output run_length,
                    output box_byte, output last_of_step, input ready);
    modport sink   (input valid, input token_kind, input run_length,
                    input box_byte, input last_of_step, output ready);
endinterface
`default_nettype wire

// ===== sv/cst_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cst_step: per-request decision logic
// next state and up to two tokens for one request
// ----------------------------------------------------------------------------
module cst_step
(
    input  wire cst_pkg::tok_state_t         state,
    input  wire cst_pkg::tok_cfg_t           cfg,
    input  wire logic                        req_type,
    input  wire logic [cst_pkg::CHAR_W-1:0]  in_char,
    output cst_pkg::step_out_t               step
);

    logic [cst_pkg::KEY_LEN_W-1:0] len;
    logic [cst_pkg::KEY_POS_W-1:0] pos;
    logic [cst_pkg::KEY_LEN_W-1:0] pos_inc;
    logic [cst_pkg::CHAR_W-1:0]    key_cur;
    logic [cst_pkg::CHAR_W-1:0]    key_first;
    logic                          emit_a;
    logic                          emit_b;
    cst_pkg::result_t              res_a;
    cst_pkg::result_t              res_b;
    cst_pkg::result_t              res_run;
    cst_pkg::result_t              res_bend;

    always_comb
    begin
        // effective key length clamped to 1..MAX_KEY_LEN
        if (cfg.key_length == '0)
            len = cst_pkg::KEY_LEN_W'(1);
        else if (cfg.key_length > cst_pkg::KEY_LEN_W'(cst_pkg::MAX_KEY_LEN))
            len = cst_pkg::KEY_LEN_W'(cst_pkg::MAX_KEY_LEN);
        else
            len = cfg.key_length;

        // stale position after the key shrank wraps to the start
        pos = ({1'b0, state.key_pos} >= len) ? '0 : state.key_pos;
        pos_inc   = {1'b0, pos} + cst_pkg::KEY_LEN_W'(1);
        key_cur   = cfg.key_chars[{pos, 3'b000} +: cst_pkg::CHAR_W];
        key_first = cfg.key_chars[cst_pkg::CHAR_W-1:0];

        res_run            = '0;
        res_run.token_kind = cst_pkg::KIND_RUN;
        res_run.run_length = state.run_count;
        res_bend            = '0;
        res_bend.token_kind = cst_pkg::KIND_BOX_END;

        emit_a = 1'b0;
        emit_b = 1'b0;
        res_a  = res_run;
        res_b  = res_bend;
        step.state_next = state;

        if (req_type == cst_pkg::REQ_EOI)
        begin
            emit_a = (state.run_count != '0);
            emit_b = state.box_open;
            step.state_next = '0;
        end
        else if (in_char inside {cst_pkg::CH_SPACE, cst_pkg::CH_TAB,
                                 cst_pkg::CH_CR, cst_pkg::CH_LF})
        begin
            // dropped, nothing changes
        end
        else if (in_char == key_cur)
        begin
            // run continues
            emit_b = state.box_open;
            step.state_next.box_open = 1'b0;
            if (state.run_count != cst_pkg::RUN_MAX)
                step.state_next.run_count = state.run_count + cst_pkg::RUN_W'(1);
            step.state_next.key_pos = (pos_inc >= len) ? '0 : pos_inc[cst_pkg::KEY_POS_W-1:0];
        end
        else if (in_char == key_first)
        begin
            // restart of the key closes the old run
            emit_a = (state.run_count != '0);
            emit_b = state.box_open;
            step.state_next.box_open  = 1'b0;
            step.state_next.run_count = cst_pkg::RUN_W'(1);
            step.state_next.key_pos   = (len > cst_pkg::KEY_LEN_W'(1)) ?
                                        cst_pkg::KEY_POS_W'(1) : '0;
        end
        else
        begin
            // box character
            emit_a = (state.run_count != '0);
            emit_b = 1'b1;
            res_b            = '0;
            res_b.token_kind = cst_pkg::KIND_BOX_CHAR;
            res_b.box_byte   = in_char;
            step.state_next.box_open  = 1'b1;
            step.state_next.run_count = '0;
            step.state_next.key_pos   = '0;
        end

        // pack present tokens to the front, mark the final one
        res_a.last_of_step = !emit_b;
        res_b.last_of_step = 1'b1;
        step.res1 = res_b;
        if (emit_a)
            step.res0 = res_a;
        else
            step.res0 = res_b;
        step.res_cnt = {1'b0, emit_a} + {1'b0, emit_b};
    end

endmodule
`default_nettype wire

// ===== sv/cst_res_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cst_res_fifo: token queue
// takes up to two tokens per cycle, and while pop is held hands out one per cycle
// ----------------------------------------------------------------------------
module cst_res_fifo
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [1:0]          push_n,
    input  wire cst_pkg::result_t    push_d0,
    input  wire cst_pkg::result_t    push_d1,
    output logic                     space2,
    output logic                     head_valid,
    output cst_pkg::result_t         head,
    input  wire logic                pop
);

    cst_pkg::result_t                 mem [cst_pkg::FIFO_DEPTH];
    logic [cst_pkg::FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [cst_pkg::FIFO_PTR_W-1:0]   wr_ptr_next;
    logic [cst_pkg::FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [cst_pkg::FIFO_PTR_W-1:0]   rd_ptr_next;
    logic [cst_pkg::FIFO_CNT_W-1:0]   cnt_reg;
    logic [cst_pkg::FIFO_CNT_W-1:0]   cnt_next;
    logic                             do_pop;

    assign space2     = (cnt_reg <= cst_pkg::FIFO_CNT_W'(cst_pkg::FIFO_DEPTH - 2));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + cst_pkg::FIFO_PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + cst_pkg::FIFO_PTR_W'(do_pop);
        cnt_next    = cnt_reg + cst_pkg::FIFO_CNT_W'(push_n)
                      - cst_pkg::FIFO_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            mem[wr_ptr_reg] <= push_d0;
        if (push_n == 2'd2)
            mem[wr_ptr_reg + cst_pkg::FIFO_PTR_W'(1)] <= push_d1;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= cst_pkg::FIFO_CNT_W'(cst_pkg::FIFO_DEPTH))
        else $error("token queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_n == 2'd2 |-> space2)
        else $error("two tokens pushed without room");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && push_n == 2'd0) |=> cnt_reg == $past(cnt_reg) - cst_pkg::FIFO_CNT_W'(1))
        else $error("token queue count lost a pop");

endmodule
`default_nettype wire

// ===== sv/cyclic_sequence_run_tokenizer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cyclic_sequence_run_tokenizer_core: key sequence run tokenizer
// splits a character stream into code runs and box text tokens
// ----------------------------------------------------------------------------
// usage
//   req_ch carries one request per handshake: a character (req_type 0) or an
//   end-of-input flush (req_type 1). tok_ch carries the tokens a request
//   causes, zero to two, the final one flagged by last_of_step.
//   cfg_we/cfg_idx/cfg_wdata write key_chars (index 0) and key_length
//   (index 1); write only while no request is in flight.
// timing
//   a request is decided in the cycle it is accepted; its tokens sit in a
//   four-entry queue, registered, before they show on tok_ch. one request per
//   cycle is taken while the queue has room for two tokens, so the rate is
//   one request per cycle unless the token side, one token per cycle, falls
//   behind (requests that cause two tokens back up the queue).
// reset
//   rst_n clears key position, run count, box flag and the queue; the key
//   registers go to all-zero characters and a length of one.
// stall
//   a stalled tok_ch holds its token; req_ch.ready drops once fewer than two
//   queue entries are free.
// ----------------------------------------------------------------------------
module cyclic_sequence_run_tokenizer_core
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    cst_req_if.sink                                req_ch,
    cst_tok_if.source                              tok_ch,
    input  wire logic                              cfg_we,
    input  wire logic [cst_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  wire logic [cst_pkg::KEY_W-1:0]         cfg_wdata
);

    // key configuration
    cst_pkg::tok_cfg_t   cfg_reg;
    // tokenizer state
    cst_pkg::tok_state_t state_reg;
    cst_pkg::step_out_t  step;

    logic                space2;
    logic                req_acc;
    logic [1:0]          push_n;
    logic                head_valid;
    cst_pkg::result_t    head;

    assign req_ch.ready = space2;
    assign req_acc      = req_ch.valid && space2;
    // tokens enter the queue only for an accepted request
    assign push_n       = req_acc ? step.res_cnt : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_chars  <= '0;
            cfg_reg.key_length <= cst_pkg::KEY_LEN_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                cst_pkg::CFG_KEY_CHARS:  cfg_reg.key_chars  <= cfg_wdata;
                cst_pkg::CFG_KEY_LENGTH: cfg_reg.key_length <= cfg_wdata[cst_pkg::KEY_LEN_W-1:0];
                default:                 ;
            endcase
        end
    end

    // decision logic for the current request
    cst_step u_step
    (
        .state    (state_reg),
        .cfg      (cfg_reg),
        .req_type (req_ch.req_type),
        .in_char  (req_ch.in_char),
        .step     (step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (req_acc)
            state_reg <= step.state_next;
    end

    // token queue, also the output register
    cst_res_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_n     (push_n),
        .push_d0    (step.res0),
        .push_d1    (step.res1),
        .space2     (space2),
        .head_valid (head_valid),
        .head       (head),
        .pop        (tok_ch.ready)
    );

    assign tok_ch.valid        = head_valid;
    assign tok_ch.token_kind   = head.token_kind;
    assign tok_ch.run_length   = head.run_length;
    assign tok_ch.box_byte     = head.box_byte;
    assign tok_ch.last_of_step = head.last_of_step;

    // flush brings the state back to its reset value
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (req_acc && req_ch.req_type == cst_pkg::REQ_EOI) |=> state_reg == '0)
        else $error("flush left tokenizer state");

    // a key position past the start means a run is open
    a_pos_has_run: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.key_pos != '0 |-> state_reg.run_count != '0)
        else $error("key position without open run");

    // open box text and an open run never coexist
    a_box_no_run: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.box_open |-> state_reg.run_count == '0)
        else $error("box text open alongside a run");

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the cyclic sequence run tokenizer
// drives character and end-of-input requests, predicts the token stream from
// a shadow copy of key registers and tokenizer state, checks every token
// ----------------------------------------------------------------------------
module testbench;
    import cst_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 1_000_000;
    // settle time after the last token before a register write or the end
    localparam int unsigned DRAIN_CYCLES = 8;
    // long token-side hold-off used to fill the result queue
    localparam int unsigned HOLD_CYCLES  = 200;
    // cap on printed mismatch lines, all mismatches are still counted
    localparam int unsigned PRINT_CAP    = 100;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [KEY_W-1:0]     cfg_wdata;

    cst_req_if req_ch ();
    cst_tok_if tok_ch ();

    cyclic_sequence_run_tokenizer_core u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_ch    (req_ch),
        .tok_ch    (tok_ch),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // shadow copy of key registers and tokenizer state
    logic [KEY_W-1:0]     shadow_key_chars;
    logic [KEY_LEN_W-1:0] shadow_key_len;
    logic [KEY_POS_W-1:0] shadow_pos;
    logic [RUN_W-1:0]     shadow_run;
    logic                 shadow_box;

    // tokens predicted and not yet seen on tok_ch, oldest first
    result_t     tokens_due[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // idle chances in percent, and a kick that starts a token-side hold-off
    int unsigned send_idle_pct = 38;
    int unsigned recv_idle_pct = 66;
    int unsigned hold_kick     = 0;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // key length in use: zero acts as one, anything above the maximum clips
    function automatic int unsigned key_span();
        if (shadow_key_len == 0)
            return 1;
        if (shadow_key_len > MAX_KEY_LEN)
            return MAX_KEY_LEN;
        return shadow_key_len;
    endfunction

    function automatic logic [CHAR_W-1:0] key_byte(int unsigned idx);
        return shadow_key_chars[CHAR_W*idx +: CHAR_W];
    endfunction

    function automatic result_t make_tok(token_kind_t kind, logic [RUN_W-1:0] run,
                                         logic [CHAR_W-1:0] ch);
        result_t tok;
        tok.token_kind   = kind;
        tok.run_length   = run;
        tok.box_byte     = ch;
        tok.last_of_step = 1'b0;
        return tok;
    endfunction

    function automatic logic [CHAR_W-1:0] pick_blank();
        case ($urandom_range(3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // advance the shadow state by one accepted request, queue its tokens
    function automatic void tokenize_req(logic kind_in, logic [CHAR_W-1:0] ch);
        result_t     toks[$];
        int unsigned span;
        int unsigned pos;
        span = key_span();
        if (kind_in == REQ_EOI)
        begin
            // flush whatever is open, back to the reset state
            if (shadow_run != 0)
                toks = {toks, make_tok(KIND_RUN, shadow_run, '0)};
            if (shadow_box)
                toks = {toks, make_tok(KIND_BOX_END, '0, '0)};
            shadow_run = '0;
            shadow_box = 1'b0;
            shadow_pos = '0;
        end
        else
        begin
            // blanks leave no trace at all
            if (ch == CH_SPACE || ch == CH_TAB || ch == CH_CR || ch == CH_LF)
                return;
            pos = shadow_pos;
            // a position left beyond a shrunk key wraps to the start
            if (pos >= span)
                pos = 0;
            if (ch == key_byte(pos))
            begin
                // run goes on, box text ends
                if (shadow_box)
                begin
                    toks = {toks, make_tok(KIND_BOX_END, '0, '0)};
                    shadow_box = 1'b0;
                end
                if (shadow_run != RUN_MAX)
                    shadow_run = shadow_run + 1'b1;
                pos = pos + 1;
                shadow_pos = (pos >= span) ? '0 : KEY_POS_W'(pos);
            end
            else if (ch == key_byte(0))
            begin
                // first key character out of turn: close the run, open a new one
                if (shadow_run != 0)
                    toks = {toks, make_tok(KIND_RUN, shadow_run, '0)};
                if (shadow_box)
                begin
                    toks = {toks, make_tok(KIND_BOX_END, '0, '0)};
                    shadow_box = 1'b0;
                end
                shadow_run = RUN_W'(1);
                shadow_pos = (span > 1) ? KEY_POS_W'(1) : '0;
            end
            else
            begin
                // anything else closes the run and goes out as box text
                if (shadow_run != 0)
                    toks = {toks, make_tok(KIND_RUN, shadow_run, '0)};
                toks = {toks, make_tok(KIND_BOX_CHAR, '0, ch)};
                shadow_run = '0;
                shadow_pos = '0;
                shadow_box = 1'b1;
            end
        end
        if (toks.size() > 0)
            toks[toks.size()-1].last_of_step = 1'b1;
        tokens_due = {tokens_due, toks};
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string what, int unsigned want, int unsigned got);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
        mismatch_count++;
    endtask

    // every token taken on tok_ch is held against the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && tok_ch.valid && tok_ch.ready)
        begin
            if (tokens_due.size() == 0)
                report_mismatch("token with none due, kind", 0, tok_ch.token_kind);
            else
            begin
                want = tokens_due.pop_front();
                if (tok_ch.token_kind !== want.token_kind)
                    report_mismatch("token_kind", want.token_kind, tok_ch.token_kind);
                if (tok_ch.run_length !== want.run_length)
                    report_mismatch("run_length", want.run_length, tok_ch.run_length);
                if (tok_ch.box_byte !== want.box_byte)
                    report_mismatch("box_byte", want.box_byte, tok_ch.box_byte);
                if (tok_ch.last_of_step !== want.last_of_step)
                    report_mismatch("last_of_step", want.last_of_step, tok_ch.last_of_step);
            end
        end
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // token side: random stalls, plus a long hold-off each time it is kicked
    initial
    begin : tok_sink
        int unsigned hold_left;
        int unsigned hold_seen;
        hold_left    = 0;
        hold_seen    = 0;
        tok_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_kick != hold_seen)
            begin
                hold_seen = hold_kick;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                tok_ch.ready <= 1'b0;
            end
            else
                tok_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // request side helpers, all entered right after a rising edge
    // ------------------------------------------------------------------------

    // offer one request, with random idle cycles ahead of it, until accepted
    task automatic send_req(logic kind_in, logic [CHAR_W-1:0] ch);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind_in;
        req_ch.in_char  <= ch;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        tokenize_req(kind_in, ch);
    endtask

    // stop offering and wait until every predicted token has come
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (tokens_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [KEY_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_KEY_CHARS)
            shadow_key_chars = data;
        else
            shadow_key_len = data[KEY_LEN_W-1:0];
        @(posedge clk);
    endtask

    // key bytes are given last key character first; length upper bits are junk
    task automatic set_key(logic [KEY_W-1:0] chars, logic [KEY_LEN_W-1:0] len);
        write_reg(CFG_KEY_CHARS, chars);
        write_reg(CFG_KEY_LENGTH, (KEY_W'({$urandom, $urandom}) << KEY_LEN_W) | KEY_W'(len));
    endtask

    // key of lower-case letters from a narrow set, so repeats are common
    task automatic set_random_key(logic [KEY_LEN_W-1:0] len);
        logic [KEY_W-1:0] chars;
        for (int i = 0; i < MAX_KEY_LEN; i++)
            chars[CHAR_W*i +: CHAR_W] = 8'h61 + CHAR_W'($urandom_range(7));
        set_key(chars, len);
    endtask

    // sender and token-side idle rates
    task automatic set_idle(int unsigned send_pct, int unsigned recv_pct);
        send_idle_pct  = send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset key: one all-zero character
    task automatic test_reset_key();
        send_req(REQ_CHAR, 8'h00);
        send_req(REQ_CHAR, 8'h00);
        send_req(REQ_CHAR, 8'hFF);   // run and box character from one request
        send_req(REQ_EOI, 8'hFF);
        wait_idle();
    endtask

    // blanks, runs, restarts, box text and flushes with a three-letter key
    task automatic test_code_and_box();
        set_key(KEY_W'("CBA"), KEY_LEN_W'(3));
        send_req(REQ_CHAR, CH_SPACE);
        send_req(REQ_CHAR, CH_TAB);
        send_req(REQ_CHAR, CH_CR);
        send_req(REQ_CHAR, CH_LF);
        send_req(REQ_CHAR, "A");
        send_req(REQ_CHAR, "B");
        send_req(REQ_CHAR, CH_SPACE);
        send_req(REQ_CHAR, "C");
        send_req(REQ_CHAR, "A");
        send_req(REQ_CHAR, "B");
        send_req(REQ_CHAR, "A");     // out of turn: closes the run, starts a new one
        send_req(REQ_CHAR, "x");
        send_req(REQ_CHAR, "y");
        send_req(REQ_CHAR, "B");     // key character but not the first: box text
        send_req(REQ_CHAR, "A");     // closes box text
        send_req(REQ_EOI, 8'h00);
        send_req(REQ_EOI, 8'h00);    // nothing open
        wait_idle();
    endtask

    // key length zero, above the maximum, and exactly the maximum
    task automatic test_key_length_extremes();
        set_key(KEY_W'("Q"), KEY_LEN_W'(0));
        send_req(REQ_CHAR, "Q");
        send_req(REQ_CHAR, "Q");
        send_req(REQ_CHAR, "R");
        send_req(REQ_EOI, 8'h00);
        wait_idle();
        set_key('1, KEY_LEN_W'(15));
        repeat (9) send_req(REQ_CHAR, 8'hFF);
        send_req(REQ_EOI, 8'h00);
        wait_idle();
        set_key(KEY_W'("87654321"), KEY_LEN_W'(8));
        for (int i = 0; i < 10; i++)
            send_req(REQ_CHAR, key_byte(i % MAX_KEY_LEN));
        send_req(REQ_EOI, 8'h00);
        wait_idle();
    endtask

    // key shrinks while the position sits beyond the new length
    task automatic test_key_shrink();
        set_key(KEY_W'("HGFEDCBA"), KEY_LEN_W'(8));
        for (int i = 0; i < 6; i++)
            send_req(REQ_CHAR, key_byte(i));
        wait_idle();
        write_reg(CFG_KEY_LENGTH, KEY_W'(3));
        send_req(REQ_CHAR, "A");
        send_req(REQ_CHAR, "B");
        send_req(REQ_EOI, 8'h00);
        wait_idle();
    endtask

    // token side held off while requests keep coming, then a full pause
    task automatic test_backpressure();
        set_idle(0, 0);
        set_key(KEY_W'("CBA"), KEY_LEN_W'(3));
        hold_kick <= hold_kick + 1;
        for (int i = 0; i < 40; i++)
        begin
            // alternate one- and two-token requests
            send_req(REQ_CHAR, "A");
            send_req(REQ_CHAR, 8'h80 + CHAR_W'(i));
        end
        wait_idle();
        for (int i = 0; i < 12; i++)
            send_req(REQ_CHAR, 8'h80 + CHAR_W'(i));
        send_req(REQ_EOI, 8'h00);
        wait_idle();
    endtask

    // mostly runs that follow the key, with box text, broken runs and noise
    task automatic run_random_phase(int unsigned n_items);
        int unsigned done_cnt;
        int unsigned sel;
        int unsigned n;
        logic [CHAR_W-1:0] ch;
        done_cnt = 0;
        while (done_cnt < n_items)
        begin
            sel = $urandom_range(99);
            if (sel < 50)
            begin
                n = $urandom_range(3 * key_span() + 2, 1);
                for (int j = 0; j < n; j++)
                begin
                    if ($urandom_range(11) == 0)
                        send_req(REQ_CHAR, pick_blank());
                    send_req(REQ_CHAR, key_byte(j % key_span()));
                end
                done_cnt += n;
            end
            else if (sel < 70)
            begin
                n = $urandom_range(5, 1);
                for (int j = 0; j < n; j++)
                begin
                    if ($urandom_range(1) == 0)
                        ch = 8'h61 + CHAR_W'($urandom_range(15));
                    else
                        ch = CHAR_W'($urandom);
                    send_req(REQ_CHAR, ch);
                end
                done_cnt += n;
            end
            else if (sel < 80)
            begin
                // key prefix cut short by a random byte
                n = $urandom_range(key_span(), 1);
                for (int j = 0; j < n; j++)
                    send_req(REQ_CHAR, key_byte(j));
                send_req(REQ_CHAR, CHAR_W'($urandom));
                done_cnt += n + 1;
            end
            else if (sel < 92)
            begin
                send_req(REQ_CHAR, CHAR_W'($urandom));
                done_cnt++;
            end
            else
            begin
                send_req(REQ_EOI, CHAR_W'($urandom));
                done_cnt++;
            end
        end
        wait_idle();
    endtask

    task automatic test_random();
        set_idle(38, 66);
        set_random_key(KEY_LEN_W'($urandom_range(MAX_KEY_LEN, 2)));
        run_random_phase(190);
        set_random_key(KEY_LEN_W'($urandom_range(MAX_KEY_LEN, 1)));
        run_random_phase(190);
        set_idle(66, 38);
        set_random_key(KEY_LEN_W'(1));
        run_random_phase(190);
        set_random_key(KEY_LEN_W'($urandom_range(15)));
        run_random_phase(190);
        set_idle(0, 0);
        set_random_key(KEY_LEN_W'(MAX_KEY_LEN));
        run_random_phase(190);
        set_random_key(KEY_LEN_W'($urandom_range(MAX_KEY_LEN, 2)));
        run_random_phase(190);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = '0;
        cfg_wdata        = '0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = REQ_CHAR;
        req_ch.in_char   = '0;
        // shadow state follows the reset values of the block
        shadow_key_chars = '0;
        shadow_key_len   = KEY_LEN_W'(1);
        shadow_pos       = '0;
        shadow_run       = '0;
        shadow_box       = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_key();
        test_code_and_box();
        test_key_length_extremes();
        test_key_shrink();
        test_random();
        test_backpressure();

        wait_idle();
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/cst_pkg.sv
sv/cst_if.sv
sv/cst_step.sv
sv/cst_res_fifo.sv
sv/cyclic_sequence_run_tokenizer_core.sv
sim/testbench.sv
